>>> src/nppt_pkg.sv
package nppt_pkg;

    // One stored path point; also the unpacked view of an append request.
    typedef struct packed {
        logic signed [23:0] wz;
        logic signed [23:0] vy;
        logic signed [23:0] vx;
        logic signed [18:0] yaw;
        logic signed [23:0] y;
        logic signed [23:0] x;
    } point_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [18:0] yaw;
    } pose_t;

    typedef struct packed {
        logic [15:0] pos_gain;
        logic [15:0] ang_gain;
        logic [22:0] pos_allow;
        logic [17:0] ang_allow;
        logic [22:0] goal_dist_tol;
        logic [17:0] goal_yaw_tol;
    } cfg_t;

    typedef enum logic [2:0] {
        STAT_EMPTY   = 3'd0,
        STAT_GOAL    = 3'd1,
        STAT_POS_ERR = 3'd2,
        STAT_ANG_ERR = 3'd3,
        STAT_TRACK   = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] wz;
        logic               goal;
        status_t            status;
    } result_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    localparam logic [2:0] CFG_POS_GAIN      = 3'd0;
    localparam logic [2:0] CFG_ANG_GAIN      = 3'd1;
    localparam logic [2:0] CFG_POS_ALLOW     = 3'd2;
    localparam logic [2:0] CFG_ANG_ALLOW     = 3'd3;
    localparam logic [2:0] CFG_GOAL_DIST_TOL = 3'd4;
    localparam logic [2:0] CFG_GOAL_YAW_TOL  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RD_TGT,
        ST_RD_LAST,
        ST_LAW_GO,
        ST_LAW_WAIT,
        ST_OUT
    } state_t;

    // Feedforward plus gain*error (Q24) rounded to Q16, ties up, saturated to 24 bits.
    function automatic logic signed [23:0] sat_correct(input logic signed [23:0] ff,
                                                       input logic signed [41:0] prod);
        logic signed [42:0] rnd;
        logic signed [34:0] q;
        logic signed [35:0] sum;
        logic signed [23:0] res;
        rnd = 43'(prod) + 43'sd128;
        q   = rnd[42:8];
        sum = 36'(ff) + 36'(q);
        if (sum > 36'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (sum < -36'sd8388608) begin
            res = -24'sh800000;
        end else begin
            res = sum[23:0];
        end
        return res;
    endfunction

endpackage

>>> src/nearest_point_path_tracker.sv
// Nearest-point path tracker.
// Input stream (s_*): one request per accepted beat; s_tuser carries the op
// (clear path, append point, control tick), s_tdata the point or pose fields.
// Clear and append give no result. A tick gives exactly one
// result on m_*: commanded velocities, goal flag and status.
// A tick with N stored points makes one memory read per point in the
// nearest-point scan, drains a three-stage distance pipeline, makes two reads
// for the target and final points and runs three stages of control arithmetic.
// A tick on an empty path skips the scan and goes straight to the output state.
// Path points live in a simple dual-port memory; unwritten entries are never read.
// Configuration writes (cfg_*) are always taken and land in the next cycle;
// write them only while no tick is in flight.
// Reset clears the path length, the control state and the gains and limits to
// their defaults; memory contents are kept. The result sits in an output
// register: a stalled receiver holds it there, new requests are still taken
// while it waits, and a later tick holds its own result until the slot frees.
module nearest_point_path_tracker #(
    parameter int PATH_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: in_x[23:0], in_y[47:24], in_yaw[66:48], ff_vx[90:67],
    //          ff_vy[114:91], ff_wz[138:115], zero pad[143:139]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,   // op[1:0]
    // m_tdata: cmd_vx[23:0], cmd_vy[47:24], cmd_wz[71:48], at_goal[72],
    //          status[75:73], zero pad[79:76]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [22:0]  cfg_data
);
    import nppt_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int LW = AW + 1;

    state_t          state_reg, state_next;
    logic [LW-1:0]   len_reg;
    logic [AW-1:0]   scan_idx_reg;
    pose_t           pose_reg;
    logic            empty_reg;
    point_t          tgt_reg;
    cfg_t            cfg_reg;
    logic            m_valid_reg;
    result_t         m_res_reg;

    logic            s_acc;
    logic [1:0]      s_op;
    point_t          s_point;
    logic [AW-1:0]   last_idx, tgt_idx;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_raddr;
    point_t          mem_rdata;
    logic            scan_start, scan_issue, scan_busy;
    logic [AW-1:0]   best_idx;
    logic            law_start, law_done;
    result_t         law_res;
    logic            out_load;

    assign s_op          = s_tuser;
    assign s_point.x     = s_tdata[23:0];
    assign s_point.y     = s_tdata[47:24];
    assign s_point.yaw   = s_tdata[66:48];
    assign s_point.vx    = s_tdata[90:67];
    assign s_point.vy    = s_tdata[114:91];
    assign s_point.wz    = s_tdata[138:115];

    assign s_acc      = s_tvalid & s_tready;
    assign last_idx   = AW'(len_reg - LW'(1));
    assign tgt_idx    = (best_idx == last_idx) ? last_idx : AW'(best_idx + AW'(1));
    assign mem_we     = s_acc && (s_op == OP_APPEND) && (len_reg < LW'(PATH_DEPTH));
    assign scan_start = s_acc && (s_op == OP_TICK);
    assign cfg_ready  = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (scan_start) begin
                    state_next = (len_reg == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!scan_busy) begin
                    state_next = ST_RD_TGT;
                end
            end
            ST_RD_TGT:   state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_LAW_GO;
            ST_LAW_GO:   state_next = ST_LAW_WAIT;
            ST_LAW_WAIT: begin
                if (law_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready   = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = scan_idx_reg;
        scan_issue = 1'b0;
        law_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: begin
                mem_re     = 1'b1;
                scan_issue = 1'b1;
            end
            ST_DRAIN: ;
            ST_RD_TGT: begin
                mem_re    = 1'b1;
                mem_raddr = tgt_idx;
            end
            ST_RD_LAST: begin
                mem_re    = 1'b1;
                mem_raddr = last_idx;
            end
            ST_LAW_GO:   law_start = 1'b1;
            ST_LAW_WAIT: ;
            ST_OUT:      out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_acc && s_op == OP_CLEAR) begin
                len_reg <= '0;
            end else if (mem_we) begin
                len_reg <= len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_start) begin
            pose_reg.x   <= s_point.x;
            pose_reg.y   <= s_point.y;
            pose_reg.yaw <= s_point.yaw;
            empty_reg    <= (len_reg == '0);
            scan_idx_reg <= '0;
        end else if (scan_issue) begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
        // target read data lands while the final point is being read
        if (state_reg == ST_RD_LAST) begin
            tgt_reg <= mem_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_gain      <= 16'd768;
            cfg_reg.ang_gain      <= 16'd768;
            cfg_reg.pos_allow     <= 23'd13107;
            cfg_reg.ang_allow     <= 18'd13107;
            cfg_reg.goal_dist_tol <= 23'd1311;
            cfg_reg.goal_yaw_tol  <= 18'd5719;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POS_GAIN:      cfg_reg.pos_gain      <= cfg_data[15:0];
                CFG_ANG_GAIN:      cfg_reg.ang_gain      <= cfg_data[15:0];
                CFG_POS_ALLOW:     cfg_reg.pos_allow     <= cfg_data;
                CFG_ANG_ALLOW:     cfg_reg.ang_allow     <= cfg_data[17:0];
                CFG_GOAL_DIST_TOL: cfg_reg.goal_dist_tol <= cfg_data;
                CFG_GOAL_YAW_TOL:  cfg_reg.goal_yaw_tol  <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (empty_reg) begin
                m_res_reg.vx     <= '0;
                m_res_reg.vy     <= '0;
                m_res_reg.wz     <= '0;
                m_res_reg.goal   <= 1'b0;
                m_res_reg.status <= STAT_EMPTY;
            end else begin
                m_res_reg <= law_res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.status, m_res_reg.goal, m_res_reg.wz,
                       m_res_reg.vy, m_res_reg.vx};

    nppt_mem #(
        .DEPTH (PATH_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(len_reg)),
        .wdata (s_point),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nppt_scan #(
        .AW (AW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .issue     (scan_issue),
        .issue_idx (scan_idx_reg),
        .rd_data   (mem_rdata),
        .cur_x     (pose_reg.x),
        .cur_y     (pose_reg.y),
        .busy      (scan_busy),
        .best_idx  (best_idx)
    );

    nppt_law u_law (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (law_start),
        .tgt     (tgt_reg),
        .last    (mem_rdata),
        .pose    (pose_reg),
        .cfg     (cfg_reg),
        .done    (law_done),
        .res     (law_res)
    );

endmodule

>>> src/nppt_mem.sv
module nppt_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  nppt_pkg::point_t wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output nppt_pkg::point_t rdata
);
    import nppt_pkg::*;

    point_t mem [DEPTH];
    point_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/nppt_scan.sv
module nppt_scan #(
    parameter int AW = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    issue,
    input  logic [AW-1:0]           issue_idx,
    input  nppt_pkg::point_t        rd_data,
    input  logic signed [23:0]      cur_x,
    input  logic signed [23:0]      cur_y,
    output logic                    busy,
    output logic [AW-1:0]           best_idx
);
    import nppt_pkg::*;

    logic            v0_reg, v1_reg, v2_reg;
    logic [AW-1:0]   i0_reg, i1_reg, i2_reg;
    logic [24:0]     dxm_reg, dym_reg;
    logic [48:0]     sqx_reg, sqy_reg;
    logic [49:0]     best_d_reg;
    logic [AW-1:0]   best_idx_reg;

    logic signed [24:0] dx, dy;
    logic [49:0]        dist_sq;

    assign dx      = {rd_data.x[23], rd_data.x} - {cur_x[23], cur_x};
    assign dy      = {rd_data.y[23], rd_data.y} - {cur_y[23], cur_y};
    assign dist_sq = 50'(sqx_reg) + 50'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        i0_reg  <= issue_idx;
        i1_reg  <= i0_reg;
        i2_reg  <= i1_reg;
        dxm_reg <= dx[24] ? 25'(-dx) : 25'(dx);
        dym_reg <= dy[24] ? 25'(-dy) : 25'(dy);
        sqx_reg <= 49'(dxm_reg * dxm_reg);
        sqy_reg <= 49'(dym_reg * dym_reg);
    end

    // Strict compare keeps the lowest index on a tie.
    always_ff @(posedge aclk) begin
        if (start) begin
            best_d_reg   <= '1;
            best_idx_reg <= '0;
        end else if (v2_reg && dist_sq < best_d_reg) begin
            best_d_reg   <= dist_sq;
            best_idx_reg <= i2_reg;
        end
    end

    assign busy     = v0_reg | v1_reg | v2_reg;
    assign best_idx = best_idx_reg;

endmodule

>>> src/nppt_law.sv
module nppt_law (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  nppt_pkg::point_t  tgt,
    input  nppt_pkg::point_t  last,
    input  nppt_pkg::pose_t   pose,
    input  nppt_pkg::cfg_t    cfg,
    output logic              done,
    output nppt_pkg::result_t res
);
    import nppt_pkg::*;

    logic v1_reg, v2_reg, v3_reg;

    // stage 1: differences
    logic signed [24:0] ex_reg, ey_reg;
    logic signed [19:0] eyaw_reg;
    logic [24:0]        gxm_reg, gym_reg;
    logic [19:0]        gyawm_reg;
    logic signed [23:0] ffx_reg, ffy_reg, ffw_reg;

    // stage 2: products and flags
    logic [49:0]        gx2_reg, gy2_reg;
    logic [45:0]        tol2_reg;
    logic signed [41:0] px_reg, py_reg, pw_reg;
    logic               yaw_ok_reg, pos_bad_reg, ang_bad_reg;
    logic signed [23:0] ffx2_reg, ffy2_reg, ffw2_reg;

    result_t res_reg, res_next;

    logic signed [24:0] ex, ey, gx, gy;
    logic signed [19:0] eyaw, gyaw;
    logic [24:0]        exm, eym;
    logic [19:0]        eyawm;
    logic               goal;

    assign ex   = {tgt.x[23], tgt.x} - {pose.x[23], pose.x};
    assign ey   = {tgt.y[23], tgt.y} - {pose.y[23], pose.y};
    assign eyaw = {tgt.yaw[18], tgt.yaw} - {pose.yaw[18], pose.yaw};
    assign gx   = {last.x[23], last.x} - {pose.x[23], pose.x};
    assign gy   = {last.y[23], last.y} - {pose.y[23], pose.y};
    assign gyaw = {last.yaw[18], last.yaw} - {pose.yaw[18], pose.yaw};

    assign exm   = ex_reg[24] ? 25'(-ex_reg) : 25'(ex_reg);
    assign eym   = ey_reg[24] ? 25'(-ey_reg) : 25'(ey_reg);
    assign eyawm = eyaw_reg[19] ? 20'(-eyaw_reg) : 20'(eyaw_reg);

    assign goal = (51'(gx2_reg) + 51'(gy2_reg) < 51'(tol2_reg)) && yaw_ok_reg;

    // stage 3: pick the outcome
    always_comb begin
        res_next.vx     = '0;
        res_next.vy     = '0;
        res_next.wz     = '0;
        res_next.goal   = 1'b0;
        res_next.status = STAT_TRACK;
        if (goal) begin
            res_next.goal   = 1'b1;
            res_next.status = STAT_GOAL;
        end else if (pos_bad_reg) begin
            res_next.status = STAT_POS_ERR;
        end else if (ang_bad_reg) begin
            res_next.status = STAT_ANG_ERR;
        end else begin
            res_next.vx = sat_correct(ffx2_reg, px_reg);
            res_next.vy = sat_correct(ffy2_reg, py_reg);
            res_next.wz = sat_correct(ffw2_reg, pw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ex_reg    <= ex;
            ey_reg    <= ey;
            eyaw_reg  <= eyaw;
            gxm_reg   <= gx[24] ? 25'(-gx) : 25'(gx);
            gym_reg   <= gy[24] ? 25'(-gy) : 25'(gy);
            gyawm_reg <= gyaw[19] ? 20'(-gyaw) : 20'(gyaw);
            ffx_reg   <= tgt.vx;
            ffy_reg   <= tgt.vy;
            ffw_reg   <= tgt.wz;
        end
        if (v1_reg) begin
            gx2_reg     <= 50'(gxm_reg * gxm_reg);
            gy2_reg     <= 50'(gym_reg * gym_reg);
            tol2_reg    <= 46'(cfg.goal_dist_tol * cfg.goal_dist_tol);
            px_reg      <= $signed({1'b0, cfg.pos_gain}) * ex_reg;
            py_reg      <= $signed({1'b0, cfg.pos_gain}) * ey_reg;
            pw_reg      <= $signed({1'b0, cfg.ang_gain}) * eyaw_reg;
            yaw_ok_reg  <= gyawm_reg < {2'b00, cfg.goal_yaw_tol};
            pos_bad_reg <= (exm > {2'b00, cfg.pos_allow}) || (eym > {2'b00, cfg.pos_allow});
            ang_bad_reg <= eyawm > {2'b00, cfg.ang_allow};
            ffx2_reg    <= ffx_reg;
            ffy2_reg    <= ffy_reg;
            ffw2_reg    <= ffw_reg;
        end
        if (v2_reg) begin
            res_reg <= res_next;
        end
    end

    assign done = v3_reg;
    assign res  = res_reg;

endmodule

>>> verif/nearest_point_path_tracker_tb.sv
`timescale 1ns / 1ps

module nearest_point_path_tracker_tb;
    import nppt_pkg::*;

    localparam int PATH_DEPTH = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic [2:0] REG_ORDER[6] = '{CFG_POS_GAIN, CFG_ANG_GAIN, CFG_POS_ALLOW,
                                            CFG_ANG_ALLOW, CFG_GOAL_DIST_TOL,
                                            CFG_GOAL_YAW_TOL};

    typedef longint unsigned u64_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [22:0]  cfg_data = '0;

    nearest_point_path_tracker #(.PATH_DEPTH(PATH_DEPTH)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    class tracker_scoreboard;
        point_t      path[PATH_DEPTH];
        int unsigned path_len;
        cfg_t        cfg;
        result_t     pending_cmds[$];
        int unsigned errors;

        function new();
            cfg.pos_gain      = 16'd768;
            cfg.ang_gain      = 16'd768;
            cfg.pos_allow     = 23'd13107;
            cfg.ang_allow     = 18'd13107;
            cfg.goal_dist_tol = 23'd1311;
            cfg.goal_yaw_tol  = 18'd5719;
            path_len = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        function void apply_reg(logic [2:0] idx, logic [22:0] val);
            case (idx)
                CFG_POS_GAIN:      cfg.pos_gain      = val[15:0];
                CFG_ANG_GAIN:      cfg.ang_gain      = val[15:0];
                CFG_POS_ALLOW:     cfg.pos_allow     = val[22:0];
                CFG_ANG_ALLOW:     cfg.ang_allow     = val[17:0];
                CFG_GOAL_DIST_TOL: cfg.goal_dist_tol = val[22:0];
                CFG_GOAL_YAW_TOL:  cfg.goal_yaw_tol  = val[17:0];
                default: ;
            endcase
        endfunction

        function u64_t mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Round gain*error from Q24 to Q16 (ties up), add feedforward, saturate.
        function logic signed [23:0] correct(logic signed [23:0] ff, logic [15:0] gain,
                                             longint err);
            longint acc;
            acc = longint'(gain) * err + 128;
            acc = longint'(ff) + (acc >>> 8);
            if (acc > 8388607) begin
                acc = 8388607;
            end else if (acc < -8388608) begin
                acc = -8388608;
            end
            return acc[23:0];
        endfunction

        function result_t predict_tick(point_t pose);
            result_t     r;
            u64_t        d_sq, best_d_sq, gx, gy;
            int unsigned best, tgt, last;
            longint      ex, ey, eyaw;
            r = '0;
            r.status = STAT_EMPTY;
            if (path_len == 0) begin
                return r;
            end
            best = 0;
            best_d_sq = '1;
            for (int unsigned i = 0; i < path_len; i++) begin
                gx = mag(longint'(path[i].x) - pose.x);
                gy = mag(longint'(path[i].y) - pose.y);
                d_sq = gx * gx + gy * gy;
                // strict compare keeps the first point on a tie
                if (d_sq < best_d_sq) begin
                    best_d_sq = d_sq;
                    best = i;
                end
            end
            last = path_len - 1;
            tgt = (best + 1 > last) ? last : best + 1;
            ex   = longint'(path[tgt].x) - pose.x;
            ey   = longint'(path[tgt].y) - pose.y;
            eyaw = longint'(path[tgt].yaw) - pose.yaw;
            gx = mag(longint'(path[last].x) - pose.x);
            gy = mag(longint'(path[last].y) - pose.y);
            if (gx * gx + gy * gy < u64_t'(cfg.goal_dist_tol) * cfg.goal_dist_tol
                && mag(longint'(path[last].yaw) - pose.yaw) < cfg.goal_yaw_tol) begin
                r.goal = 1'b1;
                r.status = STAT_GOAL;
            end else if (mag(ex) > cfg.pos_allow || mag(ey) > cfg.pos_allow) begin
                r.status = STAT_POS_ERR;
            end else if (mag(eyaw) > cfg.ang_allow) begin
                r.status = STAT_ANG_ERR;
            end else begin
                r.status = STAT_TRACK;
                r.vx = correct(path[tgt].vx, cfg.pos_gain, ex);
                r.vy = correct(path[tgt].vy, cfg.pos_gain, ey);
                r.wz = correct(path[tgt].wz, cfg.ang_gain, eyaw);
            end
            return r;
        endfunction

        function void note_request(logic [1:0] op, point_t req);
            case (op)
                OP_CLEAR: path_len = 0;
                OP_APPEND: begin
                    // a full path drops the point
                    if (path_len < PATH_DEPTH) begin
                        path[path_len] = req;
                        path_len++;
                    end
                end
                OP_TICK: pending_cmds.push_back(predict_tick(req));
                default: ;
            endcase
        endfunction

        function void check_result(logic [79:0] beat);
            result_t got, want;
            got.vx     = beat[23:0];
            got.vy     = beat[47:24];
            got.wz     = beat[71:48];
            got.goal   = beat[72];
            got.status = status_t'(beat[75:73]);
            if (pending_cmds.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected command: vx=%0d vy=%0d wz=%0d goal=%0b status=%0d",
                             got.vx, got.vy, got.wz, got.goal, got.status);
                end
                return;
            end
            want = pending_cmds.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("command mismatch: want vx=%0d vy=%0d wz=%0d goal=%0b status=%0d",
                             want.vx, want.vy, want.wz, want.goal, want.status);
                    $display("                  got  vx=%0d vy=%0d wz=%0d goal=%0b status=%0d",
                             got.vx, got.vy, got.wz, got.goal, got.status);
                end
            end
        endfunction
    endclass

    tracker_scoreboard sb;
    int          burst_left = 0;
    int unsigned reqs_sent = 0;
    point_t      route[$];
    int          rx_mode = 0;
    int          rx_mode_left = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: check accepted results, then stall on a pattern that shifts mode.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic point_t mk(input longint x, y, yaw, vx, vy, wz);
        point_t p;
        p.x = 24'(x);
        p.y = 24'(y);
        p.yaw = 19'(yaw);
        p.vx = 24'(vx);
        p.vy = 24'(vy);
        p.wz = 24'(wz);
        return p;
    endfunction

    function automatic point_t rnd_point();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[138:0];
    endfunction

    function automatic longint clip(input longint v, input int w);
        longint lim;
        lim = longint'(1) << (w - 1);
        if (v >= lim) begin
            return lim - 1;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint jitter(input int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send(input logic [1:0] op, input point_t req);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, req);
        if (op != OP_UNUSED) begin
            reqs_sent++;
        end
    endtask

    // Hold off requests until every command has come back, then let the block settle.
    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.apply_reg(idx, val);
    endtask

    task automatic program_regs(input int phase);
        logic [22:0] v[6];
        case (phase)
            0: v = '{23'd768, 23'd768, 23'd13107, 23'd13107, 23'd1311, 23'd5719};
            1: v = '{default: 23'h7FFFFF};
            2: v = '{default: 23'd0};
            3: v = '{23'hFFFF, 23'hFFFF, 23'h7FFFFF, 23'h3FFFF, 23'd0, 23'd0};
            default: v = '{23'($urandom), 23'($urandom), 23'($urandom_range(0, 1 << 18)),
                           23'($urandom_range(0, 1 << 16)), 23'($urandom_range(0, 8000)),
                           23'($urandom_range(0, 20000))};
        endcase
        for (int i = 0; i < 6; i++) begin
            write_reg(REG_ORDER[i], v[i]);
        end
        if (phase == 4) begin
            write_reg(CFG_UNUSED, 23'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic directed_checks();
        send(OP_TICK, mk(8388607, -8388608, -262144, 0, 0, 0));
        send(OP_UNUSED, '1);
        send(OP_APPEND, mk(0, 0, 0, 0, 0, 0));
        send(OP_TICK, mk(0, 0, 0, 0, 0, 0));
        send(OP_APPEND, mk(6000, 0, 1000, 8388607, -8388608, 8388607));
        send(OP_APPEND, mk(12000, 3000, 2000, 1000, -1000, 500));
        send(OP_APPEND, mk(20000, 6000, 3000, -8388608, 8388607, -8388608));
        // equidistant from the first two points; saturates high and low
        send(OP_TICK, mk(3000, 0, 500, 0, 0, 0));
        send(OP_TICK, mk(3000, 100, 500, 0, 0, 0));
        send(OP_TICK, mk(-20000, 0, 0, 0, 0, 0));
        send(OP_TICK, mk(6000, -14000, 1000, 0, 0, 0));
        send(OP_TICK, mk(12000, 3000, -20000, 0, 0, 0));
        send(OP_TICK, mk(20000, 6000, 3000, 0, 0, 0));
        // goal tolerances are strict: on the boundary the block keeps tracking
        send(OP_TICK, mk(20000, 6000, 8719, 0, 0, 0));
        send(OP_TICK, mk(21311, 6000, 3000, 0, 0, 0));
        send(OP_TICK, mk(21310, 6000, 3000, 0, 0, 0));
        send(OP_TICK, mk(8388607, 8388607, 262143, 0, 0, 0));
        send(OP_TICK, mk(-8388608, -8388608, -262144, 0, 0, 0));
        send(OP_APPEND, mk(-8388608, 8388607, 262143, -8388608, -8388608, 8388607));
        send(OP_TICK, mk(-8388608, 8388607, 262143, 0, 0, 0));
        send(OP_CLEAR, '1);
        send(OP_TICK, mk(1, 1, 1, 0, 0, 0));
    endtask

    task automatic run_route(input int n_pts);
        point_t req;
        longint cx, cy, cyaw;
        int     stride, yaw_stride, n_ticks, j, last_idx, off, yaw_off;
        route.delete();
        send(OP_CLEAR, rnd_point());
        cx = jitter(6000000);
        cy = jitter(6000000);
        cyaw = jitter(200000);
        case ($urandom_range(0, 2))
            0: stride = 256;
            1: stride = 4096;
            default: stride = 16384;
        endcase
        yaw_stride = $urandom_range(0, 3000);
        for (int k = 0; k < n_pts; k++) begin
            req = rnd_point();
            req.x = 24'(cx);
            req.y = 24'(cy);
            req.yaw = 19'(cyaw);
            if ($urandom_range(0, 7) != 0) begin
                req.vx = 24'(jitter(1 << 18));
                req.vy = 24'(jitter(1 << 18));
                req.wz = 24'(jitter(1 << 18));
            end
            route.push_back(req);
            if ($urandom_range(0, 31) == 0) begin
                send(OP_UNUSED, rnd_point());
            end
            send(OP_APPEND, req);
            cx = clip(cx + jitter(stride), 24);
            cy = clip(cy + jitter(stride), 24);
            cyaw = clip(cyaw + jitter(yaw_stride), 19);
        end
        last_idx = (route.size() > PATH_DEPTH) ? PATH_DEPTH - 1 : route.size() - 1;
        n_ticks = (n_pts > PATH_DEPTH) ? 6 : $urandom_range(1, 6);
        repeat (n_ticks) begin
            j = ($urandom_range(0, 3) == 0) ? last_idx : $urandom_range(0, last_idx);
            case ($urandom_range(0, 5))
                0: off = 0;
                1: off = 300;
                2: off = 3000;
                3: off = 12000;
                4: off = 30000;
                default: off = 8388607;
            endcase
            case ($urandom_range(0, 4))
                0: yaw_off = 0;
                1: yaw_off = 2000;
                2: yaw_off = 10000;
                3: yaw_off = 40000;
                default: yaw_off = 262143;
            endcase
            req = rnd_point();
            req.x = 24'(clip(route[j].x + jitter(off), 24));
            req.y = 24'(clip(route[j].y + jitter(off), 24));
            req.yaw = 19'(clip(route[j].yaw + jitter(yaw_off), 19));
            send(OP_TICK, req);
        end
    endtask

    task automatic run_phase(input int unsigned item_goal, input bit with_full_path);
        int pick;
        while (reqs_sent < item_goal) begin
            pick = $urandom_range(0, 19);
            if (with_full_path) begin
                // overfill so the last appends are dropped
                run_route(PATH_DEPTH + 4);
                with_full_path = 1'b0;
            end else if (pick == 0) begin
                send(2'($urandom_range(0, 3)), rnd_point());
            end else if (pick == 1) begin
                wait_drained(16);
            end else begin
                run_route(pick < 5 ? $urandom_range(13, 40) : $urandom_range(1, 12));
            end
        end
    endtask

    initial begin
        int unsigned base;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_checks();
        base = reqs_sent;
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained(16);
            program_regs(phase);
            run_phase(base + (phase + 1) * 129, phase == 3);
        end
        wait_drained(300);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
